/* rtl/rsse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsse_pkg: shared types and constants of the RLE sprite span expander
// Stream layouts, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rsse_pkg;

    // coded byte: palette index in the top bits, run length minus one below
    localparam int S_DATA_W   = 8;
    localparam int IDX_SHIFT  = 5;
    localparam int IDX_W      = 3;
    localparam int RUN_CODE_W = 5;
    localparam int RUN_W      = 6;   // 1..32

    // result tdata layout, lowest field first
    localparam int COORD_W    = 15;
    localparam int SCALE_W    = 7;
    localparam int RECT_X_LSB = 0;
    localparam int RECT_Y_LSB = RECT_X_LSB + COORD_W;
    localparam int RECT_W_LSB = RECT_Y_LSB + COORD_W;
    localparam int RECT_H_LSB = RECT_W_LSB + COORD_W;
    localparam int COLOUR_LSB = RECT_H_LSB + SCALE_W;
    localparam int M_FIELDS_W = COLOUR_LSB + IDX_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIM_W       = 9;
    localparam int ORIGIN_W    = 12;
    localparam int COUNT_W     = 4;
    localparam int MAX_SCALE   = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_ART_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ART_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_SCALE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_COUNT = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch a new coded byte
        logic step;     // cut one span off the run
        logic load;     // move the span into the output register
        logic finish;   // byte done, apply end-of-image reset if flagged
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic step_emit;  // current step produces a visible span
        logic step_done;  // current step ends the byte
        logic span_last;  // registered span was the final one of the byte
        logic out_free;   // output register can take a span
    } status_t;

endpackage

/* rtl/rsse_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsse_cfg: configuration registers
// Holds the six registers and presents the clamped working values.
// ----------------------------------------------------------------------------
module rsse_cfg #(
    parameter int MAX_ART_WIDTH  = 256,
    parameter int MAX_ART_HEIGHT = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rsse_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rsse_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic [$clog2(MAX_ART_WIDTH + 1)-1:0]    w_eff,
    output logic [$clog2(MAX_ART_HEIGHT + 1)-1:0]   h_eff,
    output logic [rsse_pkg::SCALE_W-1:0]            s_eff,
    output logic [rsse_pkg::ORIGIN_W-1:0]           origin_x,
    output logic [rsse_pkg::ORIGIN_W-1:0]           origin_y,
    output logic [rsse_pkg::COUNT_W-1:0]            colour_count
);

    localparam int CW = $clog2(MAX_ART_WIDTH + 1);
    localparam int RW = $clog2(MAX_ART_HEIGHT + 1);

    logic [rsse_pkg::DIM_W-1:0]    art_width_reg;
    logic [rsse_pkg::DIM_W-1:0]    art_height_reg;
    logic [rsse_pkg::ORIGIN_W-1:0] origin_x_reg;
    logic [rsse_pkg::ORIGIN_W-1:0] origin_y_reg;
    logic [rsse_pkg::SCALE_W-1:0]  pixel_scale_reg;
    logic [rsse_pkg::COUNT_W-1:0]  colour_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            art_width_reg    <= rsse_pkg::DIM_W'(64);
            art_height_reg   <= rsse_pkg::DIM_W'(64);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            pixel_scale_reg  <= rsse_pkg::SCALE_W'(1);
            colour_count_reg <= rsse_pkg::COUNT_W'(8);
        end else if (cfg_valid) begin
            case (cfg_index)
                rsse_pkg::CFG_ART_WIDTH:    art_width_reg    <= cfg_data[rsse_pkg::DIM_W-1:0];
                rsse_pkg::CFG_ART_HEIGHT:   art_height_reg   <= cfg_data[rsse_pkg::DIM_W-1:0];
                rsse_pkg::CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                rsse_pkg::CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                rsse_pkg::CFG_PIXEL_SCALE:  pixel_scale_reg  <= cfg_data[rsse_pkg::SCALE_W-1:0];
                rsse_pkg::CFG_COLOUR_COUNT: colour_count_reg <= cfg_data[rsse_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero means one, oversize saturates
    always_comb begin
        if (art_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(art_width_reg) > 32'(MAX_ART_WIDTH)) begin
            w_eff = CW'(MAX_ART_WIDTH);
        end else begin
            w_eff = CW'(art_width_reg);
        end

        if (art_height_reg == '0) begin
            h_eff = RW'(1);
        end else if (32'(art_height_reg) > 32'(MAX_ART_HEIGHT)) begin
            h_eff = RW'(MAX_ART_HEIGHT);
        end else begin
            h_eff = RW'(art_height_reg);
        end

        if (pixel_scale_reg == '0) begin
            s_eff = rsse_pkg::SCALE_W'(1);
        end else if (pixel_scale_reg > rsse_pkg::SCALE_W'(rsse_pkg::MAX_SCALE)) begin
            s_eff = rsse_pkg::SCALE_W'(rsse_pkg::MAX_SCALE);
        end else begin
            s_eff = pixel_scale_reg;
        end
    end

    assign origin_x     = origin_x_reg;
    assign origin_y     = origin_y_reg;
    assign colour_count = colour_count_reg;

endmodule

/* rtl/rsse_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsse_ctrl: span sequencer
// Takes a coded byte, steps it span by span and hands visible spans out.
// ----------------------------------------------------------------------------
module rsse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rsse_pkg::status_t status,
    output rsse_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FORM = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.step = 1'b1;
                if (status.step_emit) begin
                    state_next = ST_FORM;
                end else if (status.step_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FORM: begin
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.span_last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CALC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/rsse_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsse_dp: span datapath
// Position tracking, span cutting, scaling and the output register.
// ----------------------------------------------------------------------------
module rsse_dp #(
    parameter int MAX_ART_WIDTH  = 256,
    parameter int MAX_ART_HEIGHT = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  rsse_pkg::cmd_t                          cmd,
    output rsse_pkg::status_t                       status,
    input  logic [rsse_pkg::S_DATA_W-1:0]           s_tdata,
    input  logic                                    s_tlast,
    input  logic [$clog2(MAX_ART_WIDTH + 1)-1:0]    w_eff,
    input  logic [$clog2(MAX_ART_HEIGHT + 1)-1:0]   h_eff,
    input  logic [rsse_pkg::SCALE_W-1:0]            s_eff,
    input  logic [rsse_pkg::ORIGIN_W-1:0]           origin_x,
    input  logic [rsse_pkg::ORIGIN_W-1:0]           origin_y,
    input  logic [rsse_pkg::COUNT_W-1:0]            colour_count,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [rsse_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                    m_tlast
);

    localparam int CW = $clog2(MAX_ART_WIDTH + 1);
    localparam int RW = $clog2(MAX_ART_HEIGHT + 1);
    localparam int LW = (CW > rsse_pkg::RUN_W) ? CW : rsse_pkg::RUN_W;
    localparam int CO = rsse_pkg::COORD_W;
    localparam int SW = rsse_pkg::SCALE_W;
    localparam int PAD_W = rsse_pkg::M_DATA_W - rsse_pkg::M_FIELDS_W;

    logic [CW-1:0]                column_reg, column_next;
    logic [RW-1:0]                row_reg, row_next;
    logic [rsse_pkg::IDX_W-1:0]   idx_reg;
    logic [rsse_pkg::RUN_W-1:0]   run_reg, run_next;
    logic                         last_reg;
    logic                         done_reg;
    logic [CO-1:0]                px_reg, py_reg, pw_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [rsse_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                         m_tlast_reg;

    logic                         active;
    logic                         visible;
    logic [CW-1:0]                room;
    logic [rsse_pkg::RUN_W-1:0]   span;
    logic [LW:0]                  col_sum;
    logic                         wrap;
    logic [RW-1:0]                row_inc;
    logic [rsse_pkg::RUN_W-1:0]   run_left;
    logic [CW+SW-1:0]             px_full;
    logic [RW+SW-1:0]             py_full;
    logic [rsse_pkg::RUN_W+SW-1:0] pw_full;

    always_comb begin
        active  = (row_reg < h_eff) && (column_reg < w_eff);
        visible = (idx_reg != '0) && ({1'b0, idx_reg} < colour_count);
        room    = w_eff - column_reg;
        if (LW'(room) < LW'(run_reg)) begin
            span = rsse_pkg::RUN_W'(room);
        end else begin
            span = run_reg;
        end
        col_sum  = (LW+1)'(column_reg) + (LW+1)'(span);
        wrap     = col_sum >= (LW+1)'(w_eff);
        row_inc  = row_reg + RW'(1);
        run_left = run_reg - span;
        // products use the position before this step
        px_full  = (CW+SW)'(column_reg) * (CW+SW)'(s_eff);
        py_full  = (RW+SW)'(row_reg) * (RW+SW)'(s_eff);
        pw_full  = (rsse_pkg::RUN_W+SW)'(span) * (rsse_pkg::RUN_W+SW)'(s_eff);

        status.step_emit = active && visible;
        status.step_done = !active || (run_left == '0) || (wrap && (row_inc >= h_eff));
        status.span_last = done_reg;
        status.out_free  = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        run_next    = run_reg;
        if (cmd.accept) begin
            run_next = rsse_pkg::RUN_W'(s_tdata[rsse_pkg::RUN_CODE_W-1:0]) +
                       rsse_pkg::RUN_W'(1);
        end
        if (cmd.step && active) begin
            column_next = wrap ? '0 : CW'(col_sum);
            row_next    = wrap ? row_inc : row_reg;
            run_next    = run_left;
        end
        // end of image: back to the top left after this byte
        if (cmd.finish && last_reg) begin
            column_next = '0;
            row_next    = '0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (cmd.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg <= run_next;
        if (cmd.accept) begin
            idx_reg  <= s_tdata[rsse_pkg::IDX_SHIFT +: rsse_pkg::IDX_W];
            last_reg <= s_tlast;
        end
        if (cmd.step) begin
            done_reg <= status.step_done;
            px_reg   <= CO'(px_full);
            py_reg   <= CO'(py_full);
            pw_reg   <= CO'(pw_full);
        end
        if (cmd.load) begin
            // pad, colour, height, width, y, x from the top down
            m_tdata_reg <= {PAD_W'(0), idx_reg, s_eff, pw_reg,
                            CO'(origin_y) + py_reg, CO'(origin_x) + px_reg};
            m_tlast_reg <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/rle_sprite_span_expander_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_span_expander_top: RLE sprite span expander
// Turns coded sprite bytes into scaled screen rectangles, one per visible span.
// ----------------------------------------------------------------------------
// Flow: each visible span takes a cut/scale step and a load step in the
// sequencer; a transparent run takes only cut steps, and a byte past the end
// of the image ends at its first cut step. A new byte is taken only once the
// last one is done. Output stalls hold the load step.
// Reset: synchronous active-low; position to the top left, registers to
// 64 x 64, origin 0, scale 1, eight colours; output empty.
module rle_sprite_span_expander_top #(
    parameter int MAX_ART_WIDTH  = 256,
    parameter int MAX_ART_HEIGHT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // rle_byte
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rsse_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,     // last_byte
    // rect_x, rect_y, rect_width, rect_height, colour_index, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsse_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,     // last_span
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rsse_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = $clog2(MAX_ART_WIDTH + 1);
    localparam int RW = $clog2(MAX_ART_HEIGHT + 1);

    rsse_pkg::cmd_t                 cmd;
    rsse_pkg::status_t              status;
    logic [CW-1:0]                  w_eff;
    logic [RW-1:0]                  h_eff;
    logic [rsse_pkg::SCALE_W-1:0]   s_eff;
    logic [rsse_pkg::ORIGIN_W-1:0]  origin_x;
    logic [rsse_pkg::ORIGIN_W-1:0]  origin_y;
    logic [rsse_pkg::COUNT_W-1:0]   colour_count;

    rsse_cfg #(
        .MAX_ART_WIDTH  (MAX_ART_WIDTH),
        .MAX_ART_HEIGHT (MAX_ART_HEIGHT)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .s_eff        (s_eff),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .colour_count (colour_count)
    );

    rsse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rsse_dp #(
        .MAX_ART_WIDTH  (MAX_ART_WIDTH),
        .MAX_ART_HEIGHT (MAX_ART_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .s_eff        (s_eff),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .colour_count (colour_count),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

`ifndef SYNTHESIS
    // a taken byte blocks the input until its spans are done
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a request was taken");

    // a span never overwrites one that is still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("output register loaded while holding a pending span");
`endif

endmodule

/* bench/rsse_span_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsse_span_checker: scoreboard for the RLE sprite span expander
// Snoops the register, coded-byte and rectangle channels. Tracks the art
// position and register file, expands each accepted byte into the scaled
// rectangles it should produce, and checks the rectangle stream in order.
// ----------------------------------------------------------------------------
module rsse_span_checker
    import rsse_pkg::*;
#(
    parameter int MAX_ART_WIDTH  = 256,
    parameter int MAX_ART_HEIGHT = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     spans_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] wd;
        logic [SCALE_W-1:0] ht;
        logic [IDX_W-1:0]   colour;
        logic               last;
    } rect_t;

    rect_t rect_queue[$];
    rect_t got;
    rect_t want;

    logic [DIM_W-1:0]    art_w_q;
    logic [DIM_W-1:0]    art_h_q;
    logic [ORIGIN_W-1:0] org_x_q;
    logic [ORIGIN_W-1:0] org_y_q;
    logic [SCALE_W-1:0]  scale_q;
    logic [COUNT_W-1:0]  colours_q;
    int                  col_q;
    int                  row_q;

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // cut one coded byte into row-bounded spans; transparent runs only move
    task automatic expand_byte(input logic [S_DATA_W-1:0] code, input logic end_of_image);
        int          w;
        int          h;
        int          s;
        int          run;
        int          remain;
        int          piece;
        logic [31:0] sum;
        logic [IDX_W-1:0] pal;
        logic        vis;
        logic        held_ok;
        rect_t       held;
        w   = (art_w_q == 0) ? 1 : ((art_w_q > MAX_ART_WIDTH) ? MAX_ART_WIDTH : art_w_q);
        h   = (art_h_q == 0) ? 1 : ((art_h_q > MAX_ART_HEIGHT) ? MAX_ART_HEIGHT : art_h_q);
        s   = (scale_q == 0) ? 1 : ((scale_q > MAX_SCALE) ? MAX_SCALE : scale_q);
        pal = code[IDX_SHIFT +: IDX_W];
        run = code[RUN_CODE_W-1:0] + 1;
        vis = (pal != 0) && (pal < colours_q);
        held_ok = 1'b0;
        held = '0;
        if (row_q < h && col_q < w) begin
            remain = (h - row_q) * w - col_q;
            if (run > remain)
                run = remain;
            while (run != 0) begin
                piece = ((w - col_q) < run) ? (w - col_q) : run;
                if (vis) begin
                    if (held_ok)
                        rect_queue.push_back(held);
                    sum       = org_x_q + col_q * s;
                    held.x    = sum[COORD_W-1:0];
                    sum       = org_y_q + row_q * s;
                    held.y    = sum[COORD_W-1:0];
                    sum       = piece * s;
                    held.wd   = sum[COORD_W-1:0];
                    sum       = s;
                    held.ht   = sum[SCALE_W-1:0];
                    held.colour = pal;
                    held.last = 1'b0;
                    held_ok   = 1'b1;
                end
                col_q += piece;
                run   -= piece;
                if (col_q >= w) begin
                    col_q = 0;
                    row_q++;
                end
            end
            if (held_ok) begin
                held.last = 1'b1;
                rect_queue.push_back(held);
            end
        end
        if (end_of_image) begin
            col_q = 0;
            row_q = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            art_w_q    = 9'd64;
            art_h_q    = 9'd64;
            org_x_q    = '0;
            org_y_q    = '0;
            scale_q    = 7'd1;
            colours_q  = 4'd8;
            col_q      = 0;
            row_q      = 0;
            mismatches = 0;
            rect_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ART_WIDTH:    art_w_q   = cfg_data[DIM_W-1:0];
                    CFG_ART_HEIGHT:   art_h_q   = cfg_data[DIM_W-1:0];
                    CFG_ORIGIN_X:     org_x_q   = cfg_data[ORIGIN_W-1:0];
                    CFG_ORIGIN_Y:     org_y_q   = cfg_data[ORIGIN_W-1:0];
                    CFG_PIXEL_SCALE:  scale_q   = cfg_data[SCALE_W-1:0];
                    CFG_COLOUR_COUNT: colours_q = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expand_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.x      = m_tdata[RECT_X_LSB +: COORD_W];
                got.y      = m_tdata[RECT_Y_LSB +: COORD_W];
                got.wd     = m_tdata[RECT_W_LSB +: COORD_W];
                got.ht     = m_tdata[RECT_H_LSB +: SCALE_W];
                got.colour = m_tdata[COLOUR_LSB +: IDX_W];
                got.last   = m_tlast;
                if (rect_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: rectangle expected none, actual x=%0d y=%0d w=%0d h=%0d c=%0d",
                             $time, got.x, got.y, got.wd, got.ht, got.colour);
                end else begin
                    want = rect_queue.pop_front();
                    check_field("rect_x", 32'(want.x), 32'(got.x));
                    check_field("rect_y", 32'(want.y), 32'(got.y));
                    check_field("rect_width", 32'(want.wd), 32'(got.wd));
                    check_field("rect_height", 32'(want.ht), 32'(got.ht));
                    check_field("colour_index", 32'(want.colour), 32'(got.colour));
                    check_field("last_span", 32'(want.last), 32'(got.last));
                end
            end
        end
        spans_pending <= rect_queue.size();
    end

endmodule

/* bench/tb_rle_sprite_span_expander_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_sprite_span_expander_top: testbench of the RLE sprite span expander
// Feeds directed corner bytes and then random sprite images under several
// register settings and back-pressure mixes; the span checker scores output.
// ----------------------------------------------------------------------------
module tb_rle_sprite_span_expander_top;
    import rsse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_WAIT  = 100;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int spans_pending;
    int cycles        = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 70;
    int img_w         = 64;
    int img_h         = 64;

    rle_sprite_span_expander_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsse_span_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .spans_pending (spans_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays up between back-to-back requests
    task automatic send_byte(input logic [S_DATA_W-1:0] code, input logic end_flag);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= end_flag;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] ht,
                             input logic [CFG_DATA_W-1:0] ox, input logic [CFG_DATA_W-1:0] oy,
                             input logic [CFG_DATA_W-1:0] sc, input logic [CFG_DATA_W-1:0] cc);
        logic [CFG_DATA_W-1:0]  vals [6];
        logic [CFG_INDEX_W-1:0] regs [6];
        vals = '{wd, ht, ox, oy, sc, cc};
        regs = '{CFG_ART_WIDTH, CFG_ART_HEIGHT, CFG_ORIGIN_X, CFG_ORIGIN_Y,
                 CFG_PIXEL_SCALE, CFG_COLOUR_COUNT};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        img_w = (wd[DIM_W-1:0] == 0) ? 1 : ((wd[DIM_W-1:0] > 256) ? 256 : wd[DIM_W-1:0]);
        img_h = (ht[DIM_W-1:0] == 0) ? 1 : ((ht[DIM_W-1:0] > 256) ? 256 : ht[DIM_W-1:0]);
    endtask

    // drop valid, wait for every predicted rectangle, then let a
    // transparent run still in flight finish
    task automatic quiesce;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (spans_pending != 0);
        repeat (QUIET_WAIT) @(posedge aclk);
    endtask

    // mostly complete images with random runs; some trailing bytes past the
    // end of the image and some bursts of unframed noise
    task automatic random_images(input int budget);
        int                  sent;
        int                  left;
        logic [S_DATA_W-1:0] code;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 70) begin
                left = img_w * img_h;
                while (left > 0 && sent < budget) begin
                    code = S_DATA_W'($urandom);
                    left -= code[RUN_CODE_W-1:0] + 1;
                    if (left <= 0 && $urandom_range(3) == 0) begin
                        send_byte(code, 1'b0);
                        code = S_DATA_W'($urandom);
                        send_byte(code, 1'b1);
                        sent += 2;
                    end else begin
                        send_byte(code, left <= 0);
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    code = S_DATA_W'($urandom);
                    send_byte(code, $urandom_range(4) == 0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: 64 x 64, scale 1, eight colours
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h20, 1'b1);
        quiesce();

        // 5 x 3 image: clamp at image end, ignored bytes, split rows
        configure(12'd5, 12'd3, 12'hFFF, 12'hFFF, 12'd64, 12'd4);
        send_byte(8'h3F, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h21, 1'b1);
        send_byte(8'h62, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(8'hE9, 1'b1);
        send_byte(8'h22, 1'b0);
        quiesce();

        // width shrinks below the current column; zero height and scale;
        // colour count above eight
        configure(12'hE02, 12'd0, 12'h800, 12'd0, 12'd0, 12'd9);
        send_byte(8'hE1, 1'b0);
        send_byte(8'hC0, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h00, 1'b1);
        quiesce();

        // oversize dimensions and scale, no colours at all
        configure(12'h1FF, 12'h1FF, 12'd0, 12'h123, 12'h07F, 12'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3F, 1'b1);
        quiesce();

        configure(12'h100, 12'd1, 12'hFFF, 12'hFFF, 12'h07F, 12'hF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        quiesce();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 9 : ((ph < 4) ? 70 : 0);
            recv_idle_pct = (ph < 2) ? 70 : ((ph < 4) ? 9 : 0);
            if (ph % 2 == 0)
                configure(CFG_DATA_W'($urandom_range(1, 12)),
                          CFG_DATA_W'($urandom_range(1, 6)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(1, 64)),
                          CFG_DATA_W'($urandom_range(1, 8)));
            else
                configure(CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)));
            random_images(25);
            quiesce();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
